/* design/ohtab_pkg.sv */
// ----------------------------------------------------------------------------
// ohtab_pkg
// Shared types, constants and the key hash for the open addressing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package ohtab_pkg;

    localparam int KEY_W        = 64;
    localparam int VAL_W        = 64;
    localparam int LIMIT_W      = 11;
    localparam int LIVE_W       = 11;
    localparam int STATUS_W     = 3;
    localparam int SLOTS_DEFAULT = 1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd768;

    // slot word: occupied, deleted, key, value
    localparam int WORD_W       = 2 + KEY_W + VAL_W;

    localparam int HASH_STEPS   = 7;
    localparam int STEP_W       = 3;
    localparam int Q_DEPTH      = 2;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } req_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_CLEAR,
        B_RESP
    } back_state_t;

    // one round of the shift-add-xor integer hash
    function automatic logic [KEY_W-1:0] hash_step(input logic [STEP_W-1:0] step,
                                                   input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        begin
            case (step)
                3'd0:    r = (~k) + (k << 21);
                3'd1:    r = k ^ (k >> 24);
                3'd2:    r = k + (k << 3) + (k << 8);
                3'd3:    r = k ^ (k >> 14);
                3'd4:    r = k + (k << 2) + (k << 4);
                3'd5:    r = k ^ (k >> 28);
                3'd6:    r = k + (k << 31);
                default: r = k;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* design/open_addressing_hash_table_top.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top
// Linear probing key-value table with tombstones, 64-bit keys and values.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with operation, key and new_value; each
// gives exactly one result on out_valid/out_ready (status, value, live_count).
// The user must see that load_limit is written on cfg_valid/cfg_ready only
// while the table is idle; the block itself does not enforce this.
// The front hashes the key and then pushes the request into a two-entry
// queue, waiting while the queue is full. It takes a new request only after
// that push, so it can accept the next one while the back is still probing
// the previous one.
// The back picks up a request in its idle state, probes each slot with one
// RAM read (registered data) and one compare, and loads the result register
// in its response state. A get or remove on an empty table skips the probe.
// A clear sweeps all SLOTS slots, one per cycle.
// After reset the back runs the same sweep before it takes requests from the
// queue. If the receiver stalls, the result register holds and the back
// waits with its next result; the front keeps filling the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_top #(
    parameter int SLOTS = ohtab_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       operation,
    input  wire logic [ohtab_pkg::KEY_W-1:0]      key,
    input  wire logic [ohtab_pkg::VAL_W-1:0]      new_value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ohtab_pkg::STATUS_W-1:0]        status,
    output logic [ohtab_pkg::VAL_W-1:0]           value,
    output logic [ohtab_pkg::LIVE_W-1:0]          live_count,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ohtab_pkg::LIMIT_W-1:0]    load_limit
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int REQ_W  = $bits(ohtab_pkg::req_t);
    localparam int QENT_W = REQ_W + IDX_W;

    logic [ohtab_pkg::LIMIT_W-1:0] limit_reg;
    logic                          push, q_full, q_valid, pop;
    ohtab_pkg::req_t               push_req, q_req;
    logic [IDX_W-1:0]              push_slot, q_slot;
    logic [QENT_W-1:0]             q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ohtab_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= load_limit;
        end
    end

    ohtab_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .new_value (new_value),
        .push      (push),
        .q_full    (q_full),
        .push_req  (push_req),
        .push_slot (push_slot)
    );

    ohtab_queue #(
        .DATA_W (QENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_req, push_slot}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign q_req  = ohtab_pkg::req_t'(q_head[QENT_W-1:IDX_W]);
    assign q_slot = q_head[IDX_W-1:0];

    ohtab_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_limit (limit_reg),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_slot     (q_slot),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value      (value),
        .live_count (live_count)
    );

endmodule

`default_nettype wire

/* design/ohtab_ram.sv */
// ----------------------------------------------------------------------------
// ohtab_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/ohtab_front.sv */
// ----------------------------------------------------------------------------
// ohtab_front
// Takes requests, hashes the key to its start slot and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtab_front #(
    parameter int SLOTS = ohtab_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    operation,
    input  wire logic [ohtab_pkg::KEY_W-1:0]   key,
    input  wire logic [ohtab_pkg::VAL_W-1:0]   new_value,
    output logic                               push,
    input  wire logic                          q_full,
    output ohtab_pkg::req_t                    push_req,
    output logic [$clog2(SLOTS)-1:0]           push_slot
);

    localparam int IDX_W = $clog2(SLOTS);

    ohtab_pkg::front_state_t             state_reg, state_next;
    ohtab_pkg::req_t                     req_reg, req_next;
    logic [ohtab_pkg::KEY_W-1:0]         hash_reg, hash_next;
    logic [ohtab_pkg::STEP_W-1:0]        step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohtab_pkg::F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        hash_reg <= hash_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        req_next   = req_reg;
        hash_next  = hash_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ohtab_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next.op    = ohtab_pkg::op_t'(operation);
                    req_next.key   = key;
                    req_next.value = new_value;
                    hash_next      = key;
                    step_next      = '0;
                    state_next     = ohtab_pkg::F_HASH;
                end
            end
            ohtab_pkg::F_HASH:
            begin
                hash_next = ohtab_pkg::hash_step(step_reg, hash_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == ohtab_pkg::STEP_W'(ohtab_pkg::HASH_STEPS - 1))
                begin
                    state_next = ohtab_pkg::F_PUSH;
                end
            end
            ohtab_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = ohtab_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ohtab_pkg::F_IDLE;
            end
        endcase
    end

    assign push_req  = req_reg;
    assign push_slot = hash_reg[IDX_W-1:0];

endmodule

`default_nettype wire

/* design/ohtab_queue.sv */
// ----------------------------------------------------------------------------
// ohtab_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtab_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic      [DATA_W-1:0] head
);

    localparam int PTR_W = $clog2(ohtab_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(ohtab_pkg::Q_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [ohtab_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(ohtab_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* design/ohtab_back.sv */
// ----------------------------------------------------------------------------
// ohtab_back
// Probes the slot store, applies the operation and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtab_back #(
    parameter int SLOTS = ohtab_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [ohtab_pkg::LIMIT_W-1:0]    load_limit,
    input  wire logic                             q_valid,
    input  wire ohtab_pkg::req_t                  q_req,
    input  wire logic [$clog2(SLOTS)-1:0]         q_slot,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ohtab_pkg::STATUS_W-1:0]        status,
    output logic [ohtab_pkg::VAL_W-1:0]           value,
    output logic [ohtab_pkg::LIVE_W-1:0]          live_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = ((CNT_W > ohtab_pkg::LIMIT_W) ? CNT_W : ohtab_pkg::LIMIT_W) + 2;
    localparam int KEY_W = ohtab_pkg::KEY_W;
    localparam int VAL_W = ohtab_pkg::VAL_W;

    ohtab_pkg::back_state_t      state_reg, state_next;
    ohtab_pkg::op_t              op_reg, op_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [VAL_W-1:0]            nv_reg, nv_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            probe_reg, probe_next;
    logic                        tomb_found_reg, tomb_found_next;
    logic [IDX_W-1:0]            tomb_idx_reg, tomb_idx_next;
    logic [CNT_W-1:0]            entry_reg, entry_next;
    logic [CNT_W-1:0]            tomb_reg, tomb_next;
    ohtab_pkg::status_t          status_reg, status_next;
    logic [VAL_W-1:0]            value_reg, value_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ohtab_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]            out_value_reg, out_value_next;
    logic [ohtab_pkg::LIVE_W-1:0] out_live_reg, out_live_next;

    logic                        we;
    logic [IDX_W-1:0]            waddr;
    logic [ohtab_pkg::WORD_W-1:0] wdata, rdata;

    logic                        rd_occ, rd_del, hit, empty, last, tomb_any, over;
    logic [KEY_W-1:0]            rd_key;
    logic [VAL_W-1:0]            rd_value;
    logic [IDX_W-1:0]            tomb_at;

    ohtab_ram #(
        .WIDTH (ohtab_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign {rd_occ, rd_del, rd_key, rd_value} = rdata;
    assign hit      = rd_occ && (rd_key == key_reg);
    assign empty    = !rd_occ && !rd_del;
    assign last     = &probe_reg;
    assign tomb_any = tomb_found_reg || rd_del;
    assign tomb_at  = tomb_found_reg ? tomb_idx_reg : idx_reg;
    assign over     = (CMP_W'(entry_reg) + CMP_W'(tomb_reg) + CMP_W'(1))
                      > CMP_W'(load_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ohtab_pkg::B_INIT;
            idx_reg       <= '0;
            entry_reg     <= '0;
            tomb_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            entry_reg     <= entry_next;
            tomb_reg      <= tomb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        nv_reg         <= nv_next;
        probe_reg      <= probe_next;
        tomb_found_reg <= tomb_found_next;
        tomb_idx_reg   <= tomb_idx_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_live_reg   <= out_live_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        nv_next         = nv_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        tomb_found_next = tomb_found_reg;
        tomb_idx_next   = tomb_idx_reg;
        entry_next      = entry_reg;
        tomb_next       = tomb_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_live_next   = out_live_reg;
        pop             = 1'b0;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = '0;
        case (state_reg)
            // sweep after reset, store reads as empty afterwards
            ohtab_pkg::B_INIT:
            begin
                we       = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (&idx_reg)
                begin
                    state_next = ohtab_pkg::B_IDLE;
                end
            end
            ohtab_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    pop             = 1'b1;
                    op_next         = q_req.op;
                    key_next        = q_req.key;
                    nv_next         = q_req.value;
                    idx_next        = q_slot;
                    probe_next      = '0;
                    tomb_found_next = 1'b0;
                    value_next      = '0;
                    if (q_req.op == ohtab_pkg::OP_CLEAR)
                    begin
                        idx_next   = '0;
                        state_next = ohtab_pkg::B_CLEAR;
                    end
                    else if (q_req.op != ohtab_pkg::OP_PUT && entry_reg == '0)
                    begin
                        status_next = ohtab_pkg::ST_NOT_FOUND;
                        state_next  = ohtab_pkg::B_RESP;
                    end
                    else
                    begin
                        state_next = ohtab_pkg::B_READ;
                    end
                end
            end
            ohtab_pkg::B_READ:
            begin
                state_next = ohtab_pkg::B_CHECK;
            end
            ohtab_pkg::B_CHECK:
            begin
                if (hit)
                begin
                    value_next = rd_value;
                    state_next = ohtab_pkg::B_RESP;
                    case (op_reg)
                        ohtab_pkg::OP_REMOVE:
                        begin
                            we          = 1'b1;
                            wdata       = {1'b0, 1'b1, rd_key, rd_value};
                            entry_next  = entry_reg - 1'b1;
                            tomb_next   = tomb_reg + 1'b1;
                            status_next = ohtab_pkg::ST_REMOVED;
                        end
                        ohtab_pkg::OP_PUT:
                        begin
                            we          = 1'b1;
                            wdata       = {1'b1, 1'b0, rd_key, nv_reg};
                            status_next = ohtab_pkg::ST_UPDATED;
                        end
                        default:
                        begin
                            status_next = ohtab_pkg::ST_FOUND;
                        end
                    endcase
                end
                else if (empty || last)
                begin
                    state_next = ohtab_pkg::B_RESP;
                    if (op_reg != ohtab_pkg::OP_PUT)
                    begin
                        status_next = ohtab_pkg::ST_NOT_FOUND;
                    end
                    else if (over || (!tomb_any && !empty))
                    begin
                        status_next = ohtab_pkg::ST_FULL;
                    end
                    else
                    begin
                        // first tombstone passed wins over the empty slot
                        we          = 1'b1;
                        waddr       = tomb_any ? tomb_at : idx_reg;
                        wdata       = {1'b1, 1'b0, key_reg, nv_reg};
                        entry_next  = entry_reg + 1'b1;
                        status_next = ohtab_pkg::ST_INSERTED;
                        if (tomb_any && tomb_reg != '0)
                        begin
                            tomb_next = tomb_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    if (rd_del && !tomb_found_reg)
                    begin
                        tomb_found_next = 1'b1;
                        tomb_idx_next   = idx_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = ohtab_pkg::B_READ;
                end
            end
            ohtab_pkg::B_CLEAR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (&idx_reg)
                begin
                    entry_next  = '0;
                    tomb_next   = '0;
                    status_next = ohtab_pkg::ST_FULL;
                    state_next  = ohtab_pkg::B_RESP;
                end
            end
            ohtab_pkg::B_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = value_reg;
                    out_live_next   = ohtab_pkg::LIVE_W'(entry_reg);
                    state_next      = ohtab_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ohtab_pkg::B_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign value      = out_value_reg;
    assign live_count = out_live_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear probing hash table with tombstones.
// ----------------------------------------------------------------------------
// A directed table covers the empty-table cases, key extremes, updates,
// removes, tombstone reuse and clear; the refused insert follows at load
// limit 1. A random phase follows, run under several load limits. Every
// result is checked field by field against a behavioral copy of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOT = 1024;
    localparam int ANY = -1;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef struct {
        ohtab_pkg::op_t                op;
        logic [ohtab_pkg::KEY_W-1:0]   k;
        logic [ohtab_pkg::VAL_W-1:0]   nv;
        int                            exp_st;   // ANY: use the table copy only
    } stim_t;

    typedef struct {
        ohtab_pkg::status_t            st;
        logic [ohtab_pkg::VAL_W-1:0]   v;
        logic [ohtab_pkg::LIVE_W-1:0]  live;
    } answer_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [1:0]                         operation;
    logic [ohtab_pkg::KEY_W-1:0]        key;
    logic [ohtab_pkg::VAL_W-1:0]        new_value;
    logic                               out_valid;
    logic                               out_ready;
    logic [ohtab_pkg::STATUS_W-1:0]     status;
    logic [ohtab_pkg::VAL_W-1:0]        value;
    logic [ohtab_pkg::LIVE_W-1:0]       live_count;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ohtab_pkg::LIMIT_W-1:0]      load_limit;

    // bench copy of the table
    logic [ohtab_pkg::KEY_W-1:0]        tab_key [NSLOT];
    logic [ohtab_pkg::VAL_W-1:0]        tab_val [NSLOT];
    bit                                 tab_occ [NSLOT];
    bit                                 tab_del [NSLOT];
    int                                 n_live;
    int                                 n_tomb;
    int                                 limit_now;

    answer_t                            pending[$];
    logic [ohtab_pkg::KEY_W-1:0]        used_keys[$];
    int                                 errors;
    int                                 n_requests;
    int                                 n_answers;
    bit                                 hold_off;
    longint unsigned                    cycles;

    open_addressing_hash_table_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value      (value),
        .live_count (live_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .load_limit (load_limit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int home_slot(logic [ohtab_pkg::KEY_W-1:0] k);
        logic [ohtab_pkg::KEY_W-1:0] h;
        h = (~k) + (k << 21);
        h = h ^ (h >> 24);
        h = h + (h << 3) + (h << 8);
        h = h ^ (h >> 14);
        h = h + (h << 2) + (h << 4);
        h = h ^ (h >> 28);
        h = h + (h << 31);
        return int'(h[9:0]);
    endfunction

    // hit slot or -1; gap and first tombstone passed
    function automatic int find_slot(logic [ohtab_pkg::KEY_W-1:0] k, output int gap,
                                     output int tomb);
        int h;
        int p;
        h = home_slot(k);
        gap = -1;
        tomb = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            p = (h + i) % NSLOT;
            if (!tab_occ[p] && !tab_del[p])
            begin
                gap = p;
                return -1;
            end
            if (tab_del[p])
            begin
                if (tomb < 0)
                    tomb = p;
            end
            else if (tab_key[p] == k)
                return p;
        end
        return -1;
    endfunction

    function automatic answer_t table_apply(ohtab_pkg::op_t op,
                                            logic [ohtab_pkg::KEY_W-1:0] k,
                                            logic [ohtab_pkg::VAL_W-1:0] nv);
        answer_t a;
        int hit;
        int gap;
        int tomb;
        int slot;
        a.st = ohtab_pkg::ST_NOT_FOUND;
        a.v = '0;
        if (op == ohtab_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                tab_occ[i] = 0;
                tab_del[i] = 0;
            end
            n_live = 0;
            n_tomb = 0;
            a.st = ohtab_pkg::ST_FULL;
        end
        else if (op == ohtab_pkg::OP_PUT)
        begin
            hit = find_slot(k, gap, tomb);
            if (hit >= 0)
            begin
                a.v = tab_val[hit];
                tab_val[hit] = nv;
                a.st = ohtab_pkg::ST_UPDATED;
            end
            else if (n_live + n_tomb + 1 > limit_now)
                a.st = ohtab_pkg::ST_FULL;
            else
            begin
                slot = (tomb >= 0) ? tomb : gap;
                if (slot < 0)
                    a.st = ohtab_pkg::ST_FULL;
                else
                begin
                    if (tab_del[slot] && n_tomb > 0)
                        n_tomb--;
                    tab_key[slot] = k;
                    tab_val[slot] = nv;
                    tab_occ[slot] = 1;
                    tab_del[slot] = 0;
                    n_live++;
                    a.st = ohtab_pkg::ST_INSERTED;
                end
            end
        end
        else if (n_live != 0)
        begin
            hit = find_slot(k, gap, tomb);
            if (hit >= 0)
            begin
                a.v = tab_val[hit];
                if (op == ohtab_pkg::OP_REMOVE)
                begin
                    tab_occ[hit] = 0;
                    tab_del[hit] = 1;
                    n_live--;
                    n_tomb++;
                    a.st = ohtab_pkg::ST_REMOVED;
                end
                else
                    a.st = ohtab_pkg::ST_FOUND;
            end
        end
        a.live = ohtab_pkg::LIVE_W'(n_live);
        return a;
    endfunction

    // valid stays high into the next request when no idle cycles are drawn
    task automatic send_request(ohtab_pkg::op_t op, logic [ohtab_pkg::KEY_W-1:0] k,
                                logic [ohtab_pkg::VAL_W-1:0] nv, int exp_st);
        answer_t a;
        int gap_cycles;
        gap_cycles = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap_cycles = 0;
        if (gap_cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(negedge clk);
        end
        a = table_apply(op, k, nv);
        if (exp_st != ANY && int'(a.st) != exp_st)
        begin
            $error("table row: status expected %0d, copy gives %0d", exp_st, a.st);
            errors++;
        end
        pending.push_back(a);
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        new_value <= nv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_requests++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (NSLOT + 50) @(negedge clk);
    endtask

    task automatic write_limit(int lim);
        cfg_valid  <= 1'b1;
        load_limit <= ohtab_pkg::LIMIT_W'(lim);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = lim;
    endtask

    function automatic logic [ohtab_pkg::KEY_W-1:0] rand_key();
        logic [ohtab_pkg::KEY_W-1:0] k;
        k = {$urandom, $urandom};
        return k;
    endfunction

    // mostly reuses keys so that updates, hits and removes are common
    task automatic random_phase(int n, int key_pool);
        ohtab_pkg::op_t op;
        logic [ohtab_pkg::KEY_W-1:0] k;
        int r;
        used_keys.delete();
        for (int i = 0; i < key_pool; i++)
            used_keys.push_back(rand_key());
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = ohtab_pkg::OP_PUT;
            else if (r < 75)
                op = ohtab_pkg::OP_GET;
            else if (r < 99)
                op = ohtab_pkg::OP_REMOVE;
            else
                op = ohtab_pkg::OP_CLEAR;
            if ($urandom_range(0, 9) < 8)
                k = used_keys[$urandom_range(0, key_pool - 1)];
            else
                k = rand_key();
            send_request(op, k, {$urandom, $urandom}, ANY);
        end
    endtask

    // response checker
    initial
    begin
        answer_t a;
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            while (hold_off)
                @(negedge clk);
            repeat (stall) @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            n_answers++;
            if (pending.size() == 0)
            begin
                $error("result with no request waiting: status %0d", status);
                errors++;
            end
            else
            begin
                a = pending.pop_front();
                if (status !== a.st)
                begin
                    $error("status expected %0d got %0d", a.st, status);
                    errors++;
                end
                if (value !== a.v)
                begin
                    $error("value expected %h got %h", a.v, value);
                    errors++;
                end
                if (live_count !== a.live)
                begin
                    $error("live_count expected %0d got %0d", a.live, live_count);
                    errors++;
                end
            end
            @(negedge clk);
            out_ready <= 1'b0;
        end
    end

    // long receiver stall so the request queue fills
    initial
    begin
        hold_off = 1'b0;
        wait (n_requests == 40);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        stim_t rows[$];
        logic [ohtab_pkg::KEY_W-1:0] kmax;
        kmax = '1;
        errors = 0;
        n_requests = 0;
        n_answers = 0;
        n_live = 0;
        n_tomb = 0;
        limit_now = 768;
        for (int i = 0; i < NSLOT; i++)
        begin
            tab_occ[i] = 0;
            tab_del[i] = 0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = ohtab_pkg::OP_GET;
        key = '0;
        new_value = '0;
        cfg_valid = 1'b0;
        load_limit = ohtab_pkg::LIMIT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back('{ohtab_pkg::OP_GET,    64'd0, '0, ohtab_pkg::ST_NOT_FOUND});
        rows.push_back('{ohtab_pkg::OP_REMOVE, kmax,  '0, ohtab_pkg::ST_NOT_FOUND});
        rows.push_back('{ohtab_pkg::OP_PUT,    64'd0, kmax, ohtab_pkg::ST_INSERTED});
        rows.push_back('{ohtab_pkg::OP_PUT,    kmax,  64'd0, ohtab_pkg::ST_INSERTED});
        rows.push_back('{ohtab_pkg::OP_GET,    64'd0, '0, ohtab_pkg::ST_FOUND});
        rows.push_back('{ohtab_pkg::OP_GET,    kmax,  '0, ohtab_pkg::ST_FOUND});
        rows.push_back('{ohtab_pkg::OP_PUT,    kmax,  64'h5555_aaaa_0f0f_f0f0,
                         ohtab_pkg::ST_UPDATED});
        rows.push_back('{ohtab_pkg::OP_GET,    64'd1, '0, ohtab_pkg::ST_NOT_FOUND});
        rows.push_back('{ohtab_pkg::OP_REMOVE, 64'd0, '0, ohtab_pkg::ST_REMOVED});
        rows.push_back('{ohtab_pkg::OP_GET,    64'd0, '0, ohtab_pkg::ST_NOT_FOUND});
        rows.push_back('{ohtab_pkg::OP_REMOVE, 64'd0, '0, ohtab_pkg::ST_NOT_FOUND});
        // reuses tombstone
        rows.push_back('{ohtab_pkg::OP_PUT,    64'd0, 64'h1234, ohtab_pkg::ST_INSERTED});
        rows.push_back('{ohtab_pkg::OP_PUT,    64'h8000_0000_0000_0000, 64'h1, ANY});
        rows.push_back('{ohtab_pkg::OP_PUT,    64'haaaa_5555_aaaa_5555, 64'h2, ANY});
        rows.push_back('{ohtab_pkg::OP_CLEAR,  64'd0, '0, ohtab_pkg::ST_FULL});
        rows.push_back('{ohtab_pkg::OP_GET,    kmax,  '0, ohtab_pkg::ST_NOT_FOUND});
        foreach (rows[i])
            send_request(rows[i].op, rows[i].k, rows[i].nv, rows[i].exp_st);
        wait_drained();

        // smallest limit: one insert, then refusals, updates still pass
        write_limit(1);
        send_request(ohtab_pkg::OP_PUT, 64'd7, 64'd70, ohtab_pkg::ST_INSERTED);
        send_request(ohtab_pkg::OP_PUT, 64'd8, 64'd80, ohtab_pkg::ST_FULL);
        send_request(ohtab_pkg::OP_PUT, 64'd7, 64'd71, ohtab_pkg::ST_UPDATED);
        send_request(ohtab_pkg::OP_REMOVE, 64'd7, '0, ohtab_pkg::ST_REMOVED);
        // tombstone counts
        send_request(ohtab_pkg::OP_PUT, 64'd8, 64'd80, ohtab_pkg::ST_FULL);
        send_request(ohtab_pkg::OP_CLEAR, 64'd0, '0, ohtab_pkg::ST_FULL);
        random_phase(150, 6);
        wait_drained();

        write_limit(768);
        send_request(ohtab_pkg::OP_CLEAR, 64'd0, '0, ohtab_pkg::ST_FULL);
        random_phase(250, 40);
        wait_drained();

        write_limit(20);
        random_phase(150, 30);
        wait_drained();

        // limit above the slot count
        write_limit(2047);
        random_phase(150, 60);
        wait_drained();

        $display("ran %0d requests, %0d results checked", n_requests, n_answers);
        $display("load limits 1, 20, 768 and 2047, with a long result stall");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/ohtab_pkg.sv
design/ohtab_ram.sv
design/ohtab_front.sv
design/ohtab_queue.sv
design/ohtab_back.sv
design/open_addressing_hash_table_top.sv
tb/tb_top.sv
